// ===== rtl/core/gmt_pkg.sv =====
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants of the membership table
// status and outcome codes, controller states and command/status bundles
// ----------------------------------------------------------------------------
`default_nettype none

package gmt_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam logic [63:0] EXPIRY_RESET = 64'd30000;

    localparam logic [1:0] ST_ALIVE   = 2'd0;
    localparam logic [1:0] ST_SUSPECT = 2'd1;
    localparam logic [1:0] ST_DEAD    = 2'd2;

    localparam logic [1:0] OC_DONE    = 2'd0;
    localparam logic [1:0] OC_STALE   = 2'd1;
    localparam logic [1:0] OC_FULL    = 2'd2;
    localparam logic [1:0] OC_MISSING = 2'd3;

    localparam logic [1:0] MODE_GOSSIP  = 2'd0;
    localparam logic [1:0] MODE_FORCE   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP  = 2'd2;
    localparam logic [1:0] MODE_RECLAIM = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RSCAN,
        S_RLAST,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word, reset scan index
        logic scan_rd;   // issue read at scan index
        logic scan_chk;  // check data of previous read, advance
        logic decide;    // apply update to located / new entry
        logic rclm_chk;  // reclaim: judge previous read, maybe copy down
        logic rclm_end;  // reclaim: commit new count
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done; // scan index has passed all entries
        logic scan_over; // every stored entry has been checked
        logic found;     // key matched
        logic mode_rclm;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/gmt_ram.sv =====
// ----------------------------------------------------------------------------
// gmt_ram: generic single write, single read memory
// registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/gmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmt_ctrl: sequencer of the membership table
// walks the table for search or reclaim and hands the result out
// ----------------------------------------------------------------------------
`default_nettype none

module gmt_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output gmt_pkg::cmd_t       cmd,
    input  gmt_pkg::stat_t      stat
);

    gmt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            gmt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = gmt_pkg::S_SCAN;
                end
            end
            gmt_pkg::S_SCAN:
            begin
                // first read of the walk, index 0
                if (stat.scan_done)
                begin
                    // empty table
                    if (stat.mode_rclm)
                    begin
                        state_next = gmt_pkg::S_RLAST;
                    end
                    else
                    begin
                        cmd.decide = 1'b1;
                        state_next = gmt_pkg::S_OUT;
                    end
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next = stat.mode_rclm ? gmt_pkg::S_RSCAN : gmt_pkg::S_DECIDE;
                end
            end
            gmt_pkg::S_DECIDE:
            begin
                // search: check data, read next, or finish
                if (stat.found || stat.scan_over)
                begin
                    cmd.decide = 1'b1;
                    state_next = gmt_pkg::S_OUT;
                end
                else
                begin
                    cmd.scan_chk = 1'b1;
                end
            end
            gmt_pkg::S_RSCAN:
            begin
                cmd.rclm_chk = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = gmt_pkg::S_RLAST;
                end
            end
            gmt_pkg::S_RLAST:
            begin
                cmd.rclm_end = 1'b1;
                state_next = gmt_pkg::S_OUT;
            end
            gmt_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = gmt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/gmt_dpath.sv =====
// ----------------------------------------------------------------------------
// gmt_dpath: entry memory, counters and update logic
// one memory word per entry holds key, status, incarnation and death time
// ----------------------------------------------------------------------------
`default_nettype none

module gmt_dpath #(
    parameter int MAX_ENTRIES = gmt_pkg::MAX_ENTRIES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  gmt_pkg::cmd_t       cmd,
    output gmt_pkg::stat_t      stat,
    input  wire                 cfg_we,
    input  wire [63:0]          cfg_data,
    input  wire [1:0]           in_mode,
    input  wire [63:0]          in_node_id,
    input  wire [1:0]           in_status,
    input  wire [63:0]          in_inc,
    input  wire [63:0]          in_now,
    output logic [1:0]          outcome,
    output logic [1:0]          entry_status,
    output logic [63:0]         entry_incarnation,
    output logic [63:0]         entry_dead_time,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] active_count,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] removed_count
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = 64 + 2 + 64 + 64;
    localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

    logic [63:0] expiry_reg;
    logic [1:0]  mode_reg;
    logic [63:0] key_reg, inc_reg, now_reg;
    logic [1:0]  st_reg;
    logic [CW-1:0] count_reg, active_reg, idx_reg, wr_reg;
    logic        found_reg;
    logic [CW-1:0] hit_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic [63:0] r_key, r_inc, r_dt;
    logic [1:0]  r_st;
    assign {r_key, r_st, r_inc, r_dt} = rdata;

    gmt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign stat.scan_done = (idx_reg >= count_reg);
    assign stat.scan_over = (idx_reg > count_reg);
    assign stat.found = found_reg;
    assign stat.mode_rclm = (mode_reg == gmt_pkg::MODE_RECLAIM);

    // match of the word read last cycle (index idx_reg-1)
    logic match_now;
    assign match_now = cmd.scan_chk && (r_key == key_reg);

    // on a match the hit entry is read again so rdata holds it when deciding
    logic [CW-1:0] rd_idx;
    assign rd_idx = match_now ? (idx_reg - 1'b1) : idx_reg;

    // reclaim judgement on the word read last cycle
    logic expired;
    assign expired = (r_st == gmt_pkg::ST_DEAD) && ((now_reg - r_dt) >= expiry_reg);

    // update decision: on the located entry (rdata still holds it), else insert or miss
    logic [1:0]  n_st, n_oc;
    logic [63:0] n_inc, n_dt;
    logic        n_wr, n_ins;
    always_comb
    begin
        n_st = r_st;
        n_inc = r_inc;
        n_dt = r_dt;
        n_oc = gmt_pkg::OC_DONE;
        n_wr = 1'b0;
        n_ins = 1'b0;
        if (found_reg)
        begin
            case (mode_reg)
                gmt_pkg::MODE_GOSSIP:
                begin
                    n_oc = gmt_pkg::OC_STALE;
                    if (st_reg > gmt_pkg::ST_DEAD)
                    begin
                        n_oc = gmt_pkg::OC_STALE;
                    end
                    else if (r_st == gmt_pkg::ST_DEAD)
                    begin
                        if (inc_reg > r_inc && st_reg == gmt_pkg::ST_ALIVE)
                        begin
                            n_st = gmt_pkg::ST_ALIVE; n_inc = inc_reg; n_dt = '0;
                            n_oc = gmt_pkg::OC_DONE; n_wr = 1'b1;
                        end
                    end
                    else if (inc_reg > r_inc)
                    begin
                        n_st = st_reg; n_inc = inc_reg;
                        n_dt = (st_reg == gmt_pkg::ST_DEAD) ? now_reg : 64'd0;
                        n_oc = gmt_pkg::OC_DONE; n_wr = 1'b1;
                    end
                    else if (inc_reg == r_inc)
                    begin
                        if (st_reg == gmt_pkg::ST_DEAD)
                        begin
                            n_st = gmt_pkg::ST_DEAD; n_dt = now_reg;
                            n_oc = gmt_pkg::OC_DONE; n_wr = 1'b1;
                        end
                        else if (r_st == gmt_pkg::ST_ALIVE && st_reg == gmt_pkg::ST_SUSPECT)
                        begin
                            n_st = gmt_pkg::ST_SUSPECT;
                            n_oc = gmt_pkg::OC_DONE; n_wr = 1'b1;
                        end
                    end
                end
                gmt_pkg::MODE_FORCE:
                begin
                    n_st = gmt_pkg::ST_ALIVE; n_inc = inc_reg; n_dt = '0; n_wr = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            n_st = gmt_pkg::ST_ALIVE; n_inc = '0; n_dt = '0;
            case (mode_reg)
                gmt_pkg::MODE_GOSSIP,
                gmt_pkg::MODE_FORCE:
                begin
                    if (mode_reg == gmt_pkg::MODE_GOSSIP && st_reg != gmt_pkg::ST_ALIVE)
                    begin
                        n_oc = gmt_pkg::OC_STALE;
                    end
                    else if (count_reg == MAXC)
                    begin
                        n_oc = gmt_pkg::OC_FULL;
                    end
                    else
                    begin
                        n_inc = inc_reg; n_ins = 1'b1; n_wr = 1'b1;
                    end
                end
                default:
                begin
                    n_oc = gmt_pkg::OC_MISSING;
                end
            endcase
        end
    end

    logic was_live, is_live;
    assign was_live = found_reg && (r_st != gmt_pkg::ST_DEAD);
    assign is_live = (n_ins || found_reg) && (n_st != gmt_pkg::ST_DEAD);

    always_comb
    begin
        we = 1'b0;
        waddr = hit_reg[AW-1:0];
        wdata = {key_reg, n_st, n_inc, n_dt};
        raddr = rd_idx[AW-1:0];
        if (cmd.decide && n_wr)
        begin
            we = 1'b1;
            waddr = n_ins ? count_reg[AW-1:0] : hit_reg[AW-1:0];
        end
        else if (cmd.rclm_chk && !expired)
        begin
            we = 1'b1;
            waddr = wr_reg[AW-1:0];
            wdata = rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= gmt_pkg::EXPIRY_RESET;
            count_reg <= '0;
            active_reg <= '0;
            found_reg <= 1'b0;
            idx_reg <= '0;
            wr_reg <= '0;
            hit_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                expiry_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
                wr_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_rd)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.scan_chk)
            begin
                if (match_now)
                begin
                    found_reg <= 1'b1;
                    hit_reg <= idx_reg - 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.decide)
            begin
                if (n_ins)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                active_reg <= active_reg - CW'(was_live) + CW'(is_live);
            end
            if (cmd.rclm_chk)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (!expired)
                begin
                    wr_reg <= wr_reg + 1'b1;
                end
            end
            if (cmd.rclm_end)
            begin
                count_reg <= wr_reg;
            end
        end
    end

    // captured input word and result fields, valid only while in use
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            key_reg <= in_node_id;
            st_reg <= in_status;
            inc_reg <= in_inc;
            now_reg <= in_now;
        end
        if (cmd.decide)
        begin
            outcome <= n_oc;
            if (found_reg || n_ins)
            begin
                entry_status <= n_st;
                entry_incarnation <= n_inc;
                entry_dead_time <= n_dt;
            end
            else
            begin
                entry_status <= '0;
                entry_incarnation <= '0;
                entry_dead_time <= '0;
            end
            active_count <= active_reg - CW'(was_live) + CW'(is_live);
            removed_count <= '0;
        end
        if (cmd.rclm_end)
        begin
            outcome <= gmt_pkg::OC_DONE;
            entry_status <= '0;
            entry_incarnation <= '0;
            entry_dead_time <= '0;
            active_count <= active_reg;
            removed_count <= count_reg - wr_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gossip_membership_table_top.sv =====
// ----------------------------------------------------------------------------
// gossip_membership_table_top: bounded peer membership table
// gossip precedence, force alive, lookup and reclaim of expired dead peers
// ----------------------------------------------------------------------------
// One word at a time. A gossip, force or lookup word walks the entry memory
// one entry a cycle until the key matches or every stored entry has been
// checked, then the update is applied and the result is offered. A reclaim
// word reads every stored entry once and copies kept entries down, then
// commits the new fill count. The single read port of the entry memory sets
// the walk rate. The result word is held until taken, then the next word is
// accepted. Dead peers are counted out of active_count; entry fields read
// zero when no entry is addressed.
`default_nettype none

module gossip_membership_table_top #(
    parameter int MAX_ENTRIES = gmt_pkg::MAX_ENTRIES_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    // expiry_time register
    input  wire          cfg_we,
    input  wire [63:0]   cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], node_id[65:2], event_status[67:66], incarnation[131:68],
    // now_time[195:132]
    input  wire [199:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // outcome[1:0], entry_status[3:2], entry_incarnation[67:4],
    // entry_dead_time[131:68], active_count, removed_count
    output logic [((132 + 2*$clog2(MAX_ENTRIES+1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int OW = ((132 + 2*CW + 7) / 8) * 8;

    gmt_pkg::cmd_t  cmd;
    gmt_pkg::stat_t stat;

    logic [1:0]  outcome, entry_status;
    logic [63:0] entry_incarnation, entry_dead_time;
    logic [CW-1:0] active_count, removed_count;

    gmt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .stat(stat)
    );

    gmt_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_mode(s_axis_tdata[1:0]),
        .in_node_id(s_axis_tdata[65:2]),
        .in_status(s_axis_tdata[67:66]),
        .in_inc(s_axis_tdata[131:68]),
        .in_now(s_axis_tdata[195:132]),
        .outcome(outcome), .entry_status(entry_status),
        .entry_incarnation(entry_incarnation),
        .entry_dead_time(entry_dead_time),
        .active_count(active_count), .removed_count(removed_count)
    );

    assign m_axis_tdata = OW'({removed_count, active_count, entry_dead_time,
                               entry_incarnation, entry_status, outcome});

endmodule

`default_nettype wire

// ===== rtl/core/gmt_checker.sv =====
// ----------------------------------------------------------------------------
// gmt_checker: port level checks of the membership table
// one word in flight, result held while stalled
// ----------------------------------------------------------------------------
`default_nettype none

module gmt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_low
);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_low))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("accepted word not processed");

    a_ret: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("not ready after result taken");

endmodule

bind gossip_membership_table_top gmt_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_low(m_axis_tdata[15:0])
);

`default_nettype wire
